// ===== src/tpmq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmq_pkg
// Shared widths and action codes for the tree path maximum-edge query block.
// ----------------------------------------------------------------------------
package tpmq_pkg;

    localparam int IDX_W   = 10;
    localparam int DEP_W   = 10;
    localparam int OUT_W   = 16;
    localparam int CNT_W   = 11;
    localparam int EWIN_W  = 16;
    localparam int ACT_W   = 2;

    localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BUILD = 2'd1;
    localparam logic [ACT_W-1:0] ACT_QUERY = 2'd2;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

endpackage

// ===== src/tpmq_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpmq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tpmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/tree_path_max_edge_query.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_path_max_edge_query
// Binary-lifting tables of ancestors and per-jump maximum weights, held in
// one RAM, with a depth RAM; answers largest edge weight on a tree path.
// Load is taken in idle; build and query step through states that share the
// single read port of the lifting RAM. One word at a time.
// done pulses for one cycle with max_weight; the receiver cannot stall.
// Reset clears control and node_count (1024); table contents are undefined.
// ----------------------------------------------------------------------------
module tree_path_max_edge_query
    import tpmq_pkg::*;
#(
    parameter int MAX_NODES   = 1024,
    parameter int LOG_LEVELS  = 10,
    parameter int WEIGHT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             cfg_we,
    input  logic [CNT_W-1:0] cfg_wdata,
    input  logic [ACT_W-1:0] action,
    input  logic [IDX_W-1:0] node,
    input  logic [IDX_W-1:0] parent_node,
    input  logic             has_parent,
    input  logic [EWIN_W-1:0] edge_weight,
    input  logic [DEP_W-1:0] node_depth,
    input  logic [IDX_W-1:0] other_node,
    output logic             done,
    output logic [OUT_W-1:0] max_weight
);

    localparam int NB    = $clog2(MAX_NODES);
    localparam int LVL_W = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
    localparam int TAB_D = LOG_LEVELS << NB;
    localparam int TAB_A = $clog2(TAB_D);
    localparam int WB    = WEIGHT_BITS;
    localparam int EW    = 1 + IDX_W + WB;
    localparam logic [LVL_W-1:0] LVL_TOP = LVL_W'(LOG_LEVELS - 1);

    typedef enum logic [14:0] {
        S_IDLE   = 15'h0001,
        S_B_RD1  = 15'h0002,
        S_B_RD2  = 15'h0004,
        S_B_WR   = 15'h0008,
        S_Q_DU   = 15'h0010,
        S_Q_DV   = 15'h0020,
        S_Q_SWAP = 15'h0040,
        S_L1_ISS = 15'h0080,
        S_L1_CHK = 15'h0100,
        S_CMP    = 15'h0200,
        S_L2_RU  = 15'h0400,
        S_L2_RV  = 15'h0800,
        S_L2_CHK = 15'h1000,
        S_F_RV   = 15'h2000,
        S_F_DONE = 15'h4000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  node_count_reg;
    logic [LVL_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  u_reg, u_next, v_reg, v_next;
    logic [DEP_W-1:0]  du_reg, du_next, diff_reg, diff_next;
    logic [WB-1:0]     ans_reg, ans_next;
    logic [EW-1:0]     ent_reg, ent_next;
    logic              mid_ok_reg, mid_ok_next;
    logic              done_reg, done_next;
    logic [OUT_W-1:0]  max_weight_reg, max_weight_next;

    logic              tab_we;
    logic [TAB_A-1:0]  tab_waddr, tab_raddr;
    logic [EW-1:0]     tab_wdata, tab_rdata;
    logic              dep_we;
    logic [NB-1:0]     dep_raddr;
    logic [DEP_W-1:0]  dep_rdata;
    logic [IDX_W-1:0]  rd_node;
    logic [LVL_W-1:0]  rd_lvl;

    logic [CNT_W-1:0]  cnt;
    logic              u_ok, v_ok, node_ok;
    logic              r_none, r_ok, e_none;
    logic [IDX_W-1:0]  r_anc, e_anc;
    logic [WB-1:0]     r_w, e_w, wu, wv;
    logic [DEP_W-1:0]  dv;
    logic              hu, hv;

    assign cnt     = (32'(node_count_reg) > MAX_NODES) ? CNT_W'(MAX_NODES) : node_count_reg;
    assign u_ok    = 32'(u_reg) < MAX_NODES;
    assign v_ok    = 32'(v_reg) < MAX_NODES;
    assign node_ok = 32'(node) < MAX_NODES;

    assign r_none = tab_rdata[EW-1];
    assign r_anc  = tab_rdata[EW-2:WB];
    assign r_w    = tab_rdata[WB-1:0];
    assign e_none = ent_reg[EW-1];
    assign e_anc  = ent_reg[EW-2:WB];
    assign e_w    = ent_reg[WB-1:0];
    assign r_ok   = 32'(r_anc) < MAX_NODES;

    tpmq_ram #(.WIDTH(EW), .DEPTH(TAB_D)) u_tab (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    tpmq_ram #(.WIDTH(DEP_W), .DEPTH(MAX_NODES)) u_dep (
        .clk   (clk),
        .we    (dep_we),
        .waddr (NB'(node)),
        .wdata (node_depth),
        .raddr (dep_raddr),
        .rdata (dep_rdata)
    );

    assign tab_raddr = TAB_A'({rd_lvl, NB'(rd_node)});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NODE_COUNT_RST;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg          <= k_next;
        r_reg          <= r_next;
        u_reg          <= u_next;
        v_reg          <= v_next;
        du_reg         <= du_next;
        diff_reg       <= diff_next;
        ans_reg        <= ans_next;
        ent_reg        <= ent_next;
        mid_ok_reg     <= mid_ok_next;
        max_weight_reg <= max_weight_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        k_next          = k_reg;
        r_next          = r_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        du_next         = du_reg;
        diff_next       = diff_reg;
        ans_next        = ans_reg;
        ent_next        = ent_reg;
        mid_ok_next     = mid_ok_reg;
        done_next       = 1'b0;
        max_weight_next = max_weight_reg;
        tab_we          = 1'b0;
        tab_waddr       = TAB_A'({LVL_W'(0), NB'(node)});
        tab_wdata       = {!has_parent, has_parent ? parent_node : IDX_W'(0),
                           has_parent ? WB'(edge_weight) : WB'(0)};
        dep_we          = 1'b0;
        dep_raddr       = NB'(u_reg);
        rd_node         = u_reg;
        rd_lvl          = k_reg;
        dv              = v_ok ? dep_rdata : DEP_W'(0);
        hu              = 1'b0;
        hv              = 1'b0;
        wu              = '0;
        wv              = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_LOAD:
                        begin
                            tab_we = node_ok;
                            dep_we = node_ok;
                        end
                        ACT_BUILD:
                        begin
                            k_next = LVL_W'(1);
                            r_next = '0;
                            if (cnt != '0 && LOG_LEVELS > 1)
                            begin
                                state_next = S_B_RD1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            u_next     = node;
                            v_next     = other_node;
                            ans_next   = '0;
                            state_next = S_Q_DU;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_B_RD1:
            begin
                rd_node    = IDX_W'(r_reg);
                rd_lvl     = k_reg - LVL_W'(1);
                state_next = S_B_RD2;
            end
            S_B_RD2:
            begin
                ent_next    = tab_rdata;
                mid_ok_next = r_ok;
                rd_node     = r_anc;
                rd_lvl      = k_reg - LVL_W'(1);
                state_next  = S_B_WR;
            end
            S_B_WR:
            begin
                tab_we    = 1'b1;
                tab_waddr = TAB_A'({k_reg, NB'(r_reg)});
                if (e_none)
                begin
                    tab_wdata = {1'b1, IDX_W'(0), WB'(0)};
                end
                else if (!mid_ok_reg)
                begin
                    tab_wdata = {1'b1, IDX_W'(0), e_w};
                end
                else
                begin
                    tab_wdata = {r_none, r_anc, (r_w > e_w) ? r_w : e_w};
                end
                state_next = S_B_RD1;
                r_next     = r_reg + CNT_W'(1);
                if (r_reg + CNT_W'(1) == cnt)
                begin
                    r_next = '0;
                    k_next = k_reg + LVL_W'(1);
                    if (k_reg == LVL_TOP)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_Q_DU:
            begin
                dep_raddr  = NB'(u_reg);
                state_next = S_Q_DV;
            end
            S_Q_DV:
            begin
                du_next    = u_ok ? dep_rdata : DEP_W'(0);
                dep_raddr  = NB'(v_reg);
                state_next = S_Q_SWAP;
            end
            S_Q_SWAP:
            begin
                if (du_reg < dv)
                begin
                    u_next    = v_reg;
                    v_next    = u_reg;
                    diff_next = dv - du_reg;
                end
                else
                begin
                    diff_next = du_reg - dv;
                end
                k_next     = LVL_TOP;
                state_next = S_L1_ISS;
            end
            S_L1_ISS:
            begin
                state_next = S_L1_CHK;
            end
            S_L1_CHK:
            begin
                if ((32'(diff_reg) >= (32'd1 << k_reg)) && u_ok && !r_none)
                begin
                    ans_next  = (r_w > ans_reg) ? r_w : ans_reg;
                    u_next    = r_anc;
                    diff_next = DEP_W'(32'(diff_reg) - (32'd1 << k_reg));
                end
                if (k_reg == '0)
                begin
                    state_next = S_CMP;
                end
                else
                begin
                    k_next     = k_reg - LVL_W'(1);
                    state_next = S_L1_ISS;
                end
            end
            S_CMP:
            begin
                k_next = LVL_TOP;
                if (u_reg == v_reg)
                begin
                    done_next       = 1'b1;
                    max_weight_next = OUT_W'(ans_reg);
                    state_next      = S_IDLE;
                end
                else
                begin
                    state_next = S_L2_RU;
                end
            end
            S_L2_RU:
            begin
                state_next = S_L2_RV;
            end
            S_L2_RV:
            begin
                ent_next   = tab_rdata;
                rd_node    = v_reg;
                state_next = S_L2_CHK;
            end
            S_L2_CHK:
            begin
                hu = u_ok && !e_none;
                hv = v_ok && !r_none;
                if (hu && hv && (e_anc != r_anc))
                begin
                    wu       = (e_w > ans_reg) ? e_w : ans_reg;
                    ans_next = (r_w > wu) ? r_w : wu;
                    u_next   = e_anc;
                    v_next   = r_anc;
                end
                if (k_reg == '0)
                begin
                    state_next = S_F_RV;
                end
                else
                begin
                    k_next     = k_reg - LVL_W'(1);
                    state_next = S_L2_RU;
                end
            end
            S_F_RV:
            begin
                rd_lvl     = '0;
                ent_next   = tab_rdata;
                rd_node    = v_reg;
                state_next = S_F_DONE;
            end
            S_F_DONE:
            begin
                wu              = (u_ok && e_w > ans_reg) ? e_w : ans_reg;
                wv              = (v_ok && r_w > wu) ? r_w : wu;
                done_next       = 1'b1;
                max_weight_next = OUT_W'(wv);
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (state_next == S_F_RV)
        begin
            rd_node = u_next;
            rd_lvl  = '0;
        end
        else if (state_next == S_L1_ISS || state_next == S_L2_RU)
        begin
            rd_node = u_next;
            rd_lvl  = k_next;
        end
    end

    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign max_weight = max_weight_reg;

endmodule

// ===== test/tree_path_max_edge_query_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tree_path_max_edge_query_tb
// Loads hand-built trees, a random forest and a deep chain, builds the lifting
// tables and fires path queries with random gaps; every max_weight is
// checked against a predictor kept in step with each accepted word.
// ----------------------------------------------------------------------------
module tree_path_max_edge_query_tb;
    import tpmq_pkg::*;

    localparam int NODES  = 1024;
    localparam int LEVELS = 10;
    localparam int STALL_LIMIT = 200000;
    localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]  act;
        logic [IDX_W-1:0]  nd;
        logic [IDX_W-1:0]  par;
        logic              hp;
        logic [EWIN_W-1:0] w;
        logic [DEP_W-1:0]  dep;
        logic [IDX_W-1:0]  oth;
    } word_t;

    class path_max_scoreboard;
        bit [IDX_W-1:0] anc    [NODES][LEVELS];
        bit             no_anc [NODES][LEVELS];
        bit [OUT_W-1:0] jmax   [NODES][LEVELS];
        bit [DEP_W-1:0] depth  [NODES];
        int             count_cfg = int'(NODE_COUNT_RST);
        bit [OUT_W-1:0] expected_max [$];
        int             errors = 0;
        int             queries = 0;
        int             builds = 0;

        function void rebuild();
            int cnt;
            bit [IDX_W-1:0] mid;
            cnt = (count_cfg > NODES) ? NODES : count_cfg;
            for (int k = 1; k < LEVELS; k++)
                for (int r = 0; r < cnt; r++)
                begin
                    if (!no_anc[r][k-1])
                    begin
                        mid = anc[r][k-1];
                        anc[r][k]    = anc[mid][k-1];
                        no_anc[r][k] = no_anc[mid][k-1];
                        jmax[r][k]   = (jmax[r][k-1] > jmax[mid][k-1]) ?
                                       jmax[r][k-1] : jmax[mid][k-1];
                    end
                    else
                    begin
                        anc[r][k] = '0;
                        no_anc[r][k] = 1'b1;
                        jmax[r][k] = '0;
                    end
                end
        endfunction

        function bit [OUT_W-1:0] path_max(bit [IDX_W-1:0] u, bit [IDX_W-1:0] v);
            bit [OUT_W-1:0] best;
            bit [IDX_W-1:0] t;
            int diff;
            best = '0;
            if (depth[u] < depth[v])
            begin
                t = u;
                u = v;
                v = t;
            end
            diff = int'(depth[u]) - int'(depth[v]);
            for (int k = LEVELS - 1; k >= 0; k--)
                if (diff >= (1 << k) && !no_anc[u][k])
                begin
                    if (jmax[u][k] > best) best = jmax[u][k];
                    u = anc[u][k];
                    diff -= (1 << k);
                end
            if (u == v) return best;
            for (int k = LEVELS - 1; k >= 0; k--)
                if (!no_anc[u][k] && !no_anc[v][k] && anc[u][k] != anc[v][k])
                begin
                    if (jmax[u][k] > best) best = jmax[u][k];
                    if (jmax[v][k] > best) best = jmax[v][k];
                    u = anc[u][k];
                    v = anc[v][k];
                end
            if (jmax[u][0] > best) best = jmax[u][0];
            if (jmax[v][0] > best) best = jmax[v][0];
            return best;
        endfunction

        function void note_word(word_t wd);
            case (wd.act)
                ACT_LOAD:
                begin
                    anc[wd.nd][0]    = wd.hp ? wd.par : '0;
                    no_anc[wd.nd][0] = !wd.hp;
                    jmax[wd.nd][0]   = wd.hp ? wd.w : '0;
                    depth[wd.nd]     = wd.dep;
                end
                ACT_BUILD:
                begin
                    rebuild();
                    builds++;
                end
                ACT_QUERY:
                begin
                    expected_max.insert(expected_max.size(), path_max(wd.nd, wd.oth));
                    queries++;
                end
                default: ;
            endcase
        endfunction

        function void check_result(bit [OUT_W-1:0] got);
            bit [OUT_W-1:0] exp_v;
            if (expected_max.size() == 0)
            begin
                $display("%0t: unexpected result max_weight=%0d", $time, got);
                errors++;
                return;
            end
            exp_v = expected_max.pop_front();
            if (exp_v !== got)
            begin
                $display("%0t: max_weight expected %0d actual %0d", $time, exp_v, got);
                errors++;
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              cfg_we;
    logic [CNT_W-1:0]  cfg_wdata;
    logic [ACT_W-1:0]  action;
    logic [IDX_W-1:0]  node;
    logic [IDX_W-1:0]  parent_node;
    logic              has_parent;
    logic [EWIN_W-1:0] edge_weight;
    logic [DEP_W-1:0]  node_depth;
    logic [IDX_W-1:0]  other_node;
    logic              done;
    logic [OUT_W-1:0]  max_weight;

    path_max_scoreboard sb = new();
    bit quiet = 0;
    int stall_cycles = 0;
    int live_count = NODES;
    bit [DEP_W-1:0] gen_depth [NODES];

    tree_path_max_edge_query dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .action(action), .node(node), .parent_node(parent_node),
        .has_parent(has_parent), .edge_weight(edge_weight),
        .node_depth(node_depth), .other_node(other_node),
        .done(done), .max_weight(max_weight)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done) sb.check_result(max_weight);
        if ((start && !busy) || done) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > STALL_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_word(word_t wd);
        if (!quiet)
        begin
            while ($urandom_range(99) < 29)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start       <= 1'b1;
        action      <= wd.act;
        node        <= wd.nd;
        parent_node <= wd.par;
        has_parent  <= wd.hp;
        edge_weight <= wd.w;
        node_depth  <= wd.dep;
        other_node  <= wd.oth;
        do @(posedge clk); while (busy);
        sb.note_word(wd);
    endtask

    function automatic word_t blank_word(logic [ACT_W-1:0] a);
        word_t wd;
        wd = '{act: a, nd: IDX_W'($urandom), par: IDX_W'($urandom),
               hp: 1'($urandom), w: EWIN_W'($urandom),
               dep: DEP_W'($urandom), oth: IDX_W'($urandom)};
        return wd;
    endfunction

    task automatic load_node(int n, bit root, int p, bit [EWIN_W-1:0] w, int d);
        word_t wd;
        wd = blank_word(ACT_LOAD);
        wd.nd = IDX_W'(n);
        wd.hp = !root;
        if (!root) wd.par = IDX_W'(p);
        wd.w = w;
        wd.dep = DEP_W'(d);
        send_word(wd);
    endtask

    task automatic query(int u, int v);
        word_t wd;
        wd = blank_word(ACT_QUERY);
        wd.nd = IDX_W'(u);
        wd.oth = IDX_W'(v);
        send_word(wd);
    endtask

    task automatic settle();
        start <= 1'b0;
        do @(posedge clk); while (busy || sb.expected_max.size() != 0);
        repeat (80) @(posedge clk);
    endtask

    task automatic set_count(int c);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= CNT_W'(c);
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.count_cfg = c;
        if (c != 0) live_count = (c > NODES) ? NODES : c;
    endtask

    // random forest over 0..cnt-1, parents always loaded first;
    // a chain keeps nearly every node one below the previous
    task automatic load_tree(int cnt, bit chainy);
        int p;
        for (int i = 0; i < cnt; i++)
        begin
            if (i == 0 || (!chainy && $urandom_range(99) < 3))
            begin
                gen_depth[i] = '0;
                load_node(i, 1, 0, EWIN_W'($urandom), 0);
            end
            else
            begin
                if (chainy)
                    p = (i < 2 || $urandom_range(99) < 90) ? i - 1 : i - 2;
                else
                    p = $urandom_range(i - 1);
                gen_depth[i] = gen_depth[p] + DEP_W'(1);
                load_node(i, 0, p, EWIN_W'($urandom), int'(gen_depth[i]));
            end
        end
        send_word(blank_word(ACT_BUILD));
    endtask

    task automatic random_words(int n);
        int r;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 6)
                load_node($urandom_range(live_count - 1), 1'($urandom_range(1)),
                          $urandom_range(live_count - 1), EWIN_W'($urandom),
                          $urandom_range(1023));
            else if (r < 9)
                send_word(blank_word(ACT_BUILD));
            else if (r < 11)
                send_word(blank_word(ACT_UNUSED));
            else if (r < 20)
            begin
                r = $urandom_range(live_count - 1);
                query(r, r);
            end
            else
                query($urandom_range(live_count - 1), $urandom_range(live_count - 1));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        action = ACT_LOAD;
        node = '0;
        parent_node = '0;
        has_parent = 1'b0;
        edge_weight = '0;
        node_depth = '0;
        other_node = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single root, unused action, equal nodes
        set_count(1);
        load_node(0, 1, 1023, 16'hFFFF, 0);
        send_word(blank_word(ACT_UNUSED));
        send_word(blank_word(ACT_BUILD));
        query(0, 0);

        // small tree with extreme weights, all pairs
        set_count(3);
        load_node(0, 1, 0, 16'h1234, 0);
        load_node(1, 0, 0, 16'hFFFF, 1);
        load_node(2, 0, 1, 16'h0000, 2);
        send_word(blank_word(ACT_BUILD));
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                query(a, b);

        set_count(16);
        load_tree(16, 0);
        random_words(50);

        // deep chain reaching the top lifting level, loaded without gaps
        quiet = 1;
        set_count(600);
        load_tree(600, 1);
        quiet = 0;
        random_words(30);

        // zero count: build leaves the tables alone
        set_count(0);
        send_word(blank_word(ACT_BUILD));
        random_words(15);

        // count below the loaded rows: only the low rows are rebuilt
        set_count(60);
        send_word(blank_word(ACT_BUILD));
        random_words(20);

        settle();
        $display("Covered %0d queries and %0d builds, counts 0 to 600, forests and a deep chain.",
                 sb.queries, sb.builds);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
